/* rtl/core/uld_pkg.sv */
`default_nettype none

package uld_pkg;

    localparam int LINE_COUNT_BITS = 24;
    localparam int CODE_POINT_W    = 21;
    localparam int LINE_BYTES_W    = 24;
    localparam int BYTE_W          = 8;
    localparam int PEND_DEPTH      = 3;
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int SAT_EXT_W       = (LINE_COUNT_BITS > LINE_BYTES_W) ?
                                     LINE_COUNT_BITS : LINE_BYTES_W;

    localparam logic [LINE_COUNT_BITS-1:0] CNT_MAX  = {LINE_COUNT_BITS{1'b1}};
    localparam logic [LINE_BYTES_W-1:0]    BYTES_MAX = {LINE_BYTES_W{1'b1}};
    localparam logic [CODE_POINT_W-1:0]    CP_NEWLINE = CODE_POINT_W'(8'h0A);

    localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'b1000_0000;
    localparam logic [5:0] CONT_MASK  = 6'b111111;
    localparam logic [4:0] LEAD2_MASK = 5'b11111;
    localparam logic [3:0] LEAD3_MASK = 4'b1111;
    localparam logic [2:0] LEAD4_MASK = 3'b111;

    typedef enum logic [0:0] {
        KIND_CHAR = 1'b0,
        KIND_LINE = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [CODE_POINT_W-1:0]  code_point;
        logic [LINE_BYTES_W-1:0]  line_bytes;
        logic                     last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_dec_out;

    function automatic logic [2:0] f_seq_len(input logic [BYTE_W-1:0] lead);
        logic [2:0] len;
        case (lead) inside
            [8'h00:8'h7F]: len = 3'd1;
            [8'h80:8'hDF]: len = 3'd2;
            [8'hE0:8'hEF]: len = 3'd3;
            default:       len = 3'd4;
        endcase
        return len;
    endfunction

    function automatic logic [LINE_BYTES_W-1:0] f_sat_bytes(
        input logic [LINE_COUNT_BITS-1:0] v
    );
        logic [SAT_EXT_W-1:0] ext;
        ext = SAT_EXT_W'(v);
        if (ext > SAT_EXT_W'(BYTES_MAX)) begin
            return BYTES_MAX;
        end
        return ext[LINE_BYTES_W-1:0];
    endfunction

    function automatic logic [LINE_COUNT_BITS-1:0] f_cnt_inc(
        input logic [LINE_COUNT_BITS-1:0] v
    );
        if (v == CNT_MAX) begin
            return v;
        end
        return v + LINE_COUNT_BITS'(1);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/uld_decode.sv */
`default_nettype none

module uld_decode (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [uld_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_eos,
    output uld_pkg::t_dec_out          o_dec
);
    import uld_pkg::*;

    logic [BYTE_W-1:0]          r_pend [PEND_DEPTH];
    logic [BYTE_W-1:0]          n_pend [PEND_DEPTH];
    logic [1:0]                 r_pend_cnt;
    logic [1:0]                 n_pend_cnt;
    logic [LINE_COUNT_BITS-1:0] r_line_cnt;

    logic                       found;
    logic [CODE_POINT_W-1:0]    cp;
    logic [2:0]                 need;
    logic [5:0]                 cont;
    logic [LINE_COUNT_BITS-1:0] cnt_inc;
    logic [LINE_COUNT_BITS-1:0] cnt_after;
    logic [LINE_COUNT_BITS-1:0] cnt_fin;
    logic                       is_nl;
    t_result                    res_dec;
    t_result                    res_eos;

    // utf-8 sequence assembly
    always_comb begin
        found      = 1'b0;
        cp         = '0;
        n_pend     = r_pend;
        n_pend_cnt = r_pend_cnt;
        need       = f_seq_len(r_pend[0]);
        cont       = i_byte[5:0] & CONT_MASK;
        if (r_pend_cnt == 2'd0) begin
            if (i_byte < ASCII_LIMIT) begin
                found = 1'b1;
                cp    = CODE_POINT_W'(i_byte);
            end else begin
                n_pend[0]  = i_byte;
                n_pend_cnt = 2'd1;
            end
        end else if ({1'b0, r_pend_cnt} + 3'd1 == need) begin
            found      = 1'b1;
            n_pend_cnt = 2'd0;
            case (need)
                3'd2: cp = CODE_POINT_W'({r_pend[0][4:0] & LEAD2_MASK, cont});
                3'd3: cp = CODE_POINT_W'({r_pend[0][3:0] & LEAD3_MASK,
                                          r_pend[1][5:0] & CONT_MASK, cont});
                default: cp = CODE_POINT_W'({r_pend[0][2:0] & LEAD4_MASK,
                                             r_pend[1][5:0] & CONT_MASK,
                                             r_pend[2][5:0] & CONT_MASK, cont});
            endcase
        end else if (r_pend_cnt < 2'd3) begin
            n_pend[r_pend_cnt] = i_byte;
            n_pend_cnt         = r_pend_cnt + 2'd1;
        end
    end

    // line counting and result forming
    always_comb begin
        cnt_inc   = f_cnt_inc(r_line_cnt);
        is_nl     = found && (cp == CP_NEWLINE);
        cnt_after = is_nl ? '0 : cnt_inc;
        cnt_fin   = f_cnt_inc(cnt_after);

        res_dec.kind       = is_nl ? KIND_LINE : KIND_CHAR;
        res_dec.code_point = is_nl ? '0 : cp;
        res_dec.line_bytes = is_nl ? f_sat_bytes(cnt_inc) : '0;
        res_dec.last       = !i_eos;

        res_eos.kind       = KIND_LINE;
        res_eos.code_point = '0;
        res_eos.line_bytes = f_sat_bytes(cnt_fin);
        res_eos.last       = 1'b1;

        o_dec.count = {1'b0, found} + {1'b0, i_eos};
        o_dec.res0  = found ? res_dec : res_eos;
        o_dec.res1  = res_eos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= 2'd0;
            r_line_cnt <= '0;
        end else if (i_step) begin
            r_pend_cnt <= i_eos ? 2'd0 : n_pend_cnt;
            r_line_cnt <= i_eos ? '0 : cnt_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_pend <= n_pend;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/uld_fifo.sv */
`default_nettype none

module uld_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  uld_pkg::t_dec_out i_dec,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output uld_pkg::t_result  o_res
);
    import uld_pkg::*;

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic [FIFO_PTR_W-1:0] wr_ptr1;
    logic [FIFO_CNT_W-1:0] push_n;
    logic                  pop;

    always_comb begin
        wr_ptr1 = r_wr_ptr + FIFO_PTR_W'(1);
        push_n  = i_push ? FIFO_CNT_W'(i_dec.count) : '0;
        o_valid = (r_count != '0);
        pop     = o_valid && i_ready;
        o_room  = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
        o_res   = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(push_n);
            r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(pop);
            r_count  <= r_count + push_n - FIFO_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && (i_dec.count != 2'd0)) begin
            r_mem[r_wr_ptr] <= i_dec.res0;
        end
        if (i_push && (i_dec.count == 2'd2)) begin
            r_mem[wr_ptr1] <= i_dec.res1;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/utf8_decoder_line_splitter.sv */
// Decodes a byte stream as UTF-8 (length from the lead byte only, continuation
// bytes unchecked) and reports one result per code point, except that a newline
// gives a line-end result with the line's byte count, newline included. A byte
// flagged end_of_stream adds a final line-end result with the count plus one and
// returns the block to its start state. A byte enters in every cycle while the
// four-entry result queue has room for two results; a byte that causes one result
// sustains one byte per cycle, and a byte that causes two has them leave the
// queue one after the other on the result side. An input beat passes through
// an input register, then decode and queue write, before its first result beat.
`default_nettype none

module utf8_decoder_line_splitter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [uld_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic                             i_end_of_stream,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_kind,
    output logic [uld_pkg::CODE_POINT_W-1:0] o_code_point,
    output logic [uld_pkg::LINE_BYTES_W-1:0] o_line_bytes,
    output logic                             o_last
);
    import uld_pkg::*;

    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_eos;
    logic              step;
    logic              room;
    t_dec_out          dec;
    t_result           res;

    assign step       = r_in_vld && room;
    assign o_in_ready = !r_in_vld || room;

    // input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_eos  <= i_end_of_stream;
        end
    end

    uld_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_eos   (r_in_eos),
        .o_dec   (dec)
    );

    uld_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_dec   (dec),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (res)
    );

    assign o_kind       = res.kind;
    assign o_code_point = res.code_point;
    assign o_line_bytes = res.line_bytes;
    assign o_last       = res.last;

endmodule

`default_nettype wire

/* rtl/core/uld_checker.sv */
`default_nettype none

module uld_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic                             o_kind,
    input logic [uld_pkg::CODE_POINT_W-1:0] o_code_point,
    input logic [uld_pkg::LINE_BYTES_W-1:0] o_line_bytes,
    input logic                             o_last
);
    import uld_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_code_point) && $stable(o_line_bytes) && $stable(o_last))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_char_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_CHAR) |-> (o_line_bytes == '0))
        else $error("character result carries a byte count");

    a_line_no_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_LINE) |-> (o_code_point == '0)
            && (o_line_bytes != '0))
        else $error("line-end result malformed");

    a_no_nl_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_CHAR) |-> (o_code_point != CP_NEWLINE))
        else $error("newline reported as character");

endmodule

bind utf8_decoder_line_splitter uld_checker u_uld_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_kind       (o_kind),
    .o_code_point (o_code_point),
    .o_line_bytes (o_line_bytes),
    .o_last       (o_last)
);

`default_nettype wire
